// ----- rtl/tdp_pkg.sv -----
package tdp_pkg;

  localparam int STEP_W = 4;

  typedef logic [STEP_W-1:0] step_t;

  // microprogram step addresses
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_SMALL    = 4'd1;
  localparam step_t S_EVEN     = 4'd2;
  localparam step_t S_EVEN_OUT = 4'd3;
  localparam step_t S_ODD_INIT = 4'd4;
  localparam step_t S_LOOP     = 4'd5;
  localparam step_t S_MOD_WAIT = 4'd6;
  localparam step_t S_HIT      = 4'd7;
  localparam step_t S_NEXT     = 4'd8;
  localparam step_t S_PRIME    = 4'd9;
  localparam step_t S_EMIT     = 4'd10;
  localparam step_t S_EMIT_INV = 4'd11;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SET_D2,
    OP_SET_D3,
    OP_MOD_START,
    OP_D_STEP,
    OP_D_N,
    OP_EMIT,
    OP_EMIT_INV
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_START,
    C_N_LT2,
    C_N_ODD,
    C_SQ_GT_N,
    C_MOD_BUSY,
    C_REM_ZERO
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic busy;
    logic rem_zero;
  } mod_stat_t;

  function automatic ctrl_t tdp_rom(input step_t pc);
    ctrl_t c;
    unique case (pc)
      S_IDLE:     c = '{OP_LOAD,      C_NOT_START, S_IDLE};
      S_SMALL:    c = '{OP_NONE,      C_N_LT2,     S_EMIT_INV};
      S_EVEN:     c = '{OP_SET_D2,    C_N_ODD,     S_ODD_INIT};
      S_EVEN_OUT: c = '{OP_NONE,      C_ALWAYS,    S_EMIT};
      S_ODD_INIT: c = '{OP_SET_D3,    C_NEVER,     S_IDLE};
      S_LOOP:     c = '{OP_MOD_START, C_SQ_GT_N,   S_PRIME};
      S_MOD_WAIT: c = '{OP_NONE,      C_MOD_BUSY,  S_MOD_WAIT};
      S_HIT:      c = '{OP_NONE,      C_REM_ZERO,  S_EMIT};
      S_NEXT:     c = '{OP_D_STEP,    C_ALWAYS,    S_LOOP};
      S_PRIME:    c = '{OP_D_N,       C_NEVER,     S_IDLE};
      S_EMIT:     c = '{OP_EMIT,      C_ALWAYS,    S_IDLE};
      S_EMIT_INV: c = '{OP_EMIT_INV,  C_ALWAYS,    S_IDLE};
      default:    c = '{OP_NONE,      C_ALWAYS,    S_IDLE};
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/tdp_mod.sv -----
module tdp_mod
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [NUMBER_WIDTH-1:0] divisor,
  output mod_stat_t               stat
);

  localparam int CW = $clog2(NUMBER_WIDTH + 1);

  logic [NUMBER_WIDTH-1:0] rem_r, rem_nxt;
  logic [NUMBER_WIDTH-1:0] q_r, q_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic [NUMBER_WIDTH:0]   trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, q_r[NUMBER_WIDTH-1]};
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      cnt_nxt  = CW'(NUMBER_WIDTH);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = NUMBER_WIDTH'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[NUMBER_WIDTH-1:0];
      end
      q_nxt   = q_r << 1;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign stat.busy     = busy_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

// ----- rtl/trial_division_primality.sv -----
// Trial-division primality test. Pulse start with the number on in_number_in while busy is
// low; busy then stays high until the single result leaves on out_strobe for one cycle,
// which the receiver must take as it comes. Numbers below 2 return out_input_valid low and
// zeros, even numbers come back without any trial division. Odd numbers try divisors 3, 5,
// 7 and onward while divisor squared stays within the number; each trial runs one remainder
// through a one-bit-per-cycle divider.
module trial_division_primality
  import tdp_pkg::*;
#(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_number_in,
  output logic        out_strobe,
  output logic        out_input_valid,
  output logic        out_prime_flag,
  output logic [31:0] out_smallest_divisor
);

  localparam int NW = NUMBER_WIDTH;

  step_t            pc_r, pc_nxt;
  ctrl_t            ctrl;
  logic             jump;
  logic [NW-1:0]    n_r, n_nxt;
  logic [NW-1:0]    d_r, d_nxt;
  logic [NW+1:0]    sq_r, sq_nxt;
  logic             strobe_r, strobe_nxt;
  logic             valid_r, valid_nxt;
  logic             prime_r, prime_nxt;
  logic [31:0]      div_r, div_nxt;
  mod_stat_t        mstat;

  assign ctrl = tdp_rom(pc_r);
  assign busy = (pc_r != S_IDLE);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:     jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NOT_START: jump = !start;
      C_N_LT2:     jump = (n_r < NW'(2));
      C_N_ODD:     jump = n_r[0];
      C_SQ_GT_N:   jump = (sq_r > {2'b00, n_r});
      C_MOD_BUSY:  jump = mstat.busy;
      C_REM_ZERO:  jump = mstat.rem_zero;
      default:     jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r + step_t'(1);
  end

  always_comb begin
    n_nxt      = n_r;
    d_nxt      = d_r;
    sq_nxt     = sq_r;
    strobe_nxt = 1'b0;
    valid_nxt  = valid_r;
    prime_nxt  = prime_r;
    div_nxt    = div_r;
    unique case (ctrl.op)
      OP_LOAD:     n_nxt = NW'(in_number_in);
      OP_SET_D2:   d_nxt = NW'(2);
      OP_SET_D3: begin
        d_nxt  = NW'(3);
        sq_nxt = (NW + 2)'(9);
      end
      OP_D_STEP: begin
        // (d + 2)^2 = d^2 + 4d + 4
        d_nxt  = d_r + NW'(2);
        sq_nxt = sq_r + {d_r, 2'b00} + (NW + 2)'(4);
      end
      OP_D_N:      d_nxt = n_r;
      OP_EMIT: begin
        strobe_nxt = 1'b1;
        valid_nxt  = 1'b1;
        prime_nxt  = (d_r == n_r);
        div_nxt    = 32'(d_r);
      end
      OP_EMIT_INV: begin
        strobe_nxt = 1'b1;
        valid_nxt  = 1'b0;
        prime_nxt  = 1'b0;
        div_nxt    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      pc_r     <= pc_nxt;
      strobe_r <= strobe_nxt;
    end
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
    valid_r <= valid_nxt;
    prime_r <= prime_nxt;
    div_r   <= div_nxt;
  end

  tdp_mod #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.op == OP_MOD_START),
    .dividend (n_r),
    .divisor  (d_r),
    .stat     (mstat)
  );

  assign out_strobe           = strobe_r;
  assign out_input_valid      = valid_r;
  assign out_prime_flag       = prime_r;
  assign out_smallest_divisor = div_r;

endmodule
